>>> rtl/mncu_pkg.sv
// Shared types, constants and helpers of the move/negate/complement unit.
package mncu_pkg;

  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned REG_IDX_W = $clog2(REG_COUNT);

  typedef enum logic [2:0] {
    REQ_MOVE  = 3'd0,
    REQ_COMPL = 3'd1,
    REQ_NEG   = 3'd2,
    REQ_ZXBW  = 3'd3,
    REQ_ZXBL  = 3'd4,
    REQ_ZXWL  = 3'd5,
    REQ_QUAD  = 3'd6
  } req_type_e;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_WORD = 2'd1,
    SZ_LONG = 2'd2,
    SZ_QUAD = 2'd3
  } size_e;

  // condition code bit positions
  localparam int unsigned CC_N = 3;
  localparam int unsigned CC_Z = 2;
  localparam int unsigned CC_V = 1;
  localparam int unsigned CC_C = 0;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [1:0]        size;
    logic [31:0]       src_low;
    logic [31:0]       src_high;
    logic signed [4:0] dest_register;
    logic [31:0]       mem_address;
  } req_t;

  typedef struct packed {
    logic        mem_write;
    logic [31:0] write_address;
    logic [63:0] write_data;
    logic [1:0]  write_size;
    logic        reg_written;
    logic [31:0] reg_value;
    logic        flag_n;
    logic        flag_z;
    logic        flag_v;
    logic        flag_c;
    logic        overflow_trap;
  } res_t;

  // register file write request; pair writes hi into the next register
  typedef struct packed {
    logic                 en;
    logic                 pair;
    logic [REG_IDX_W-1:0] idx;
    logic [31:0]          lo;
    logic [31:0]          hi;
  } rf_wr_t;

  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    logic [31:0] m;
    case (sz)
      SZ_BYTE: m = 32'h0000_00FF;
      SZ_WORD: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] size_sign(input logic [1:0] sz);
    logic [31:0] s;
    case (sz)
      SZ_BYTE: s = 32'h0000_0080;
      SZ_WORD: s = 32'h0000_8000;
      default: s = 32'h8000_0000;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/mncu_if.sv
// Valid/ready channel interfaces for the request and result streams.
interface mncu_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        req_type;
  logic [1:0]        size;
  logic [31:0]       src_low;
  logic [31:0]       src_high;
  logic signed [4:0] dest_register;
  logic [31:0]       mem_address;

  modport source (
    output valid, req_type, size, src_low, src_high, dest_register, mem_address,
    input  ready
  );
  modport sink (
    input  valid, req_type, size, src_low, src_high, dest_register, mem_address,
    output ready
  );
endinterface

interface mncu_out_if;
  logic        valid;
  logic        ready;
  logic        mem_write;
  logic [31:0] write_address;
  logic [63:0] write_data;
  logic [1:0]  write_size;
  logic        reg_written;
  logic [31:0] reg_value;
  logic        flag_n;
  logic        flag_z;
  logic        flag_v;
  logic        flag_c;
  logic        overflow_trap;

  modport source (
    output valid, mem_write, write_address, write_data, write_size, reg_written,
           reg_value, flag_n, flag_z, flag_v, flag_c, overflow_trap,
    input  ready
  );
  modport sink (
    input  valid, mem_write, write_address, write_data, write_size, reg_written,
           reg_value, flag_n, flag_z, flag_v, flag_c, overflow_trap,
    output ready
  );
endinterface

>>> rtl/mncu_regfile.sv
// Architectural state: general register file and condition codes.
module mncu_regfile (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [mncu_pkg::REG_IDX_W-1:0] rd_idx_i,
  output logic [31:0]                    rd_data_o,
  input  mncu_pkg::rf_wr_t               wr_i,
  input  logic                           cc_we_i,
  input  logic [3:0]                     cc_d_i,
  output logic [3:0]                     cc_o
);
  import mncu_pkg::*;

  logic [31:0]          regs_q [REG_COUNT];
  logic [3:0]           cc_q;
  logic [REG_IDX_W-1:0] idx_hi;

  assign idx_hi    = wr_i.idx + REG_IDX_W'(1);  // wraps: last register pairs with first
  assign rd_data_o = regs_q[rd_idx_i];
  assign cc_o      = cc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_q[i] <= '0;
      end
      cc_q <= '0;
    end else begin
      for (int i = 0; i < REG_COUNT; i++) begin
        if (wr_i.en && wr_i.idx == REG_IDX_W'(i)) begin
          regs_q[i] <= wr_i.lo;
        end else if (wr_i.en && wr_i.pair && idx_hi == REG_IDX_W'(i)) begin
          regs_q[i] <= wr_i.hi;
        end
      end
      if (cc_we_i) begin
        cc_q <= cc_d_i;
      end
    end
  end
endmodule

>>> rtl/mncu_exec.sv
// Single-pass datapath: result, merge, flags and write requests for one op.
module mncu_exec (
  input  mncu_pkg::req_t   req_i,
  input  logic [31:0]      rd_data_i,
  input  logic [3:0]       cc_i,
  input  logic             trap_en_i,
  output mncu_pkg::res_t   res_o,
  output mncu_pkg::rf_wr_t rf_wr_o,
  output logic [3:0]       cc_d_o
);
  import mncu_pkg::*;

  logic [1:0]  sz;
  logic [31:0] mask;
  logic [31:0] sign;
  logic [31:0] src_m;
  logic [31:0] res;
  logic [1:0]  wsize;
  logic        do_write;
  logic        to_mem;
  logic        quad;
  logic        trap;
  logic [3:0]  cc;

  assign sz     = (req_i.size == SZ_QUAD) ? SZ_LONG : req_i.size;
  assign mask   = size_mask(sz);
  assign sign   = size_sign(sz);
  assign src_m  = req_i.src_low & mask;
  assign to_mem = req_i.dest_register[4];

  always_comb begin
    res      = '0;
    wsize    = SZ_BYTE;
    do_write = 1'b1;
    quad     = 1'b0;
    trap     = 1'b0;
    cc       = cc_i;
    case (req_i.req_type)
      REQ_MOVE, REQ_COMPL, REQ_NEG: begin
        case (req_i.req_type)
          REQ_MOVE:  res = src_m;
          REQ_COMPL: res = ~req_i.src_low & mask;
          default:   res = (32'd0 - req_i.src_low) & mask;
        endcase
        wsize   = sz;
        cc[CC_N] = |(res & sign);
        cc[CC_Z] = (res == '0);
        cc[CC_V] = 1'b0;
        if (req_i.req_type == REQ_NEG) begin
          cc[CC_C] = (res != '0);
          cc[CC_V] = (src_m == sign);  // most negative value
          trap     = (src_m == sign) && trap_en_i;
        end
      end
      REQ_ZXBW, REQ_ZXBL, REQ_ZXWL: begin
        res      = (req_i.req_type == REQ_ZXWL) ? (req_i.src_low & 32'h0000_FFFF)
                                                : (req_i.src_low & 32'h0000_00FF);
        wsize    = (req_i.req_type == REQ_ZXBW) ? SZ_WORD : SZ_LONG;
        cc[CC_N] = 1'b0;
        cc[CC_Z] = (res == '0);
        cc[CC_V] = 1'b0;
      end
      REQ_QUAD: begin
        wsize    = SZ_QUAD;
        quad     = 1'b1;
        cc[CC_N] = req_i.src_high[31];
        cc[CC_Z] = ((req_i.src_low | req_i.src_high) == '0);
        cc[CC_V] = 1'b0;
      end
      default: begin
        do_write = 1'b0;  // unused opcode: no write, flags kept
      end
    endcase
  end

  always_comb begin
    rf_wr_o.en   = do_write && !to_mem;
    rf_wr_o.pair = quad;
    rf_wr_o.idx  = req_i.dest_register[REG_IDX_W-1:0];
    rf_wr_o.lo   = quad ? req_i.src_low
                        : ((rd_data_i & ~size_mask(wsize)) | res);
    rf_wr_o.hi   = req_i.src_high;

    res_o               = '0;
    res_o.mem_write     = do_write && to_mem;
    if (do_write && to_mem) begin
      res_o.write_address = req_i.mem_address;
      res_o.write_data    = quad ? {req_i.src_high, req_i.src_low} : {32'd0, res};
      res_o.write_size    = wsize;
    end
    res_o.reg_written   = rf_wr_o.en;
    res_o.reg_value     = rf_wr_o.en ? rf_wr_o.lo : 32'd0;
    res_o.flag_n        = cc[CC_N];
    res_o.flag_z        = cc[CC_Z];
    res_o.flag_v        = cc[CC_V];
    res_o.flag_c        = cc[CC_C];
    res_o.overflow_trap = trap;
  end

  assign cc_d_o = cc;
endmodule

>>> rtl/move_negate_complement_unit.sv
// Top level of the integer move/complement/negate execution unit.
//
// Channels: in_i takes one move-class instruction per transfer (type, size,
// source longwords, destination register or memory, address); out_o returns
// one result per instruction: memory write request, register update value,
// the N/Z/V/C codes afterwards and the overflow trap request.
// cfg_we_i/cfg_data_i write the overflow trap enable; write it only while
// the unit is idle.
// An input transfer passes through the input register, then the result
// register, before its result is valid. Throughput: one instruction per
// cycle unless a low out_o.ready holds the result stage; the single execute
// pass reads and updates the register file and condition codes in the same
// cycle, so dependent instructions follow back to back with no bubble.
// Stall: while out_o.ready is low the result register holds; the input
// register still takes one more instruction, then in_i.ready drops until
// the result drains.
// Reset (rst_ni low, asynchronous): registers, condition codes and trap
// enable go to zero and both pipeline stages empty.
module move_negate_complement_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  mncu_in_if.sink    in_i,
  mncu_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i
);
  import mncu_pkg::*;

  req_t   req_q;
  logic   req_valid_q;
  res_t   res_q;
  res_t   res_d;
  logic   res_valid_q;
  logic   trap_en_q;
  logic   in_xfer;
  logic   advance;    // execute pass: input stage moves into result stage
  rf_wr_t rf_wr;
  rf_wr_t rf_commit;  // write request gated by the execute pass
  logic [31:0] rd_data;
  logic [3:0]  cc_q;
  logic [3:0]  cc_d;

  assign in_xfer   = in_i.valid && in_i.ready;
  assign advance   = req_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !req_valid_q || advance;

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      req_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q.req_type      <= in_i.req_type;
      req_q.size          <= in_i.size;
      req_q.src_low       <= in_i.src_low;
      req_q.src_high      <= in_i.src_high;
      req_q.dest_register <= in_i.dest_register;
      req_q.mem_address   <= in_i.mem_address;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trap_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      trap_en_q <= cfg_data_i;
    end
  end

  always_comb begin
    rf_commit    = rf_wr;
    rf_commit.en = rf_wr.en && advance;
  end

  // architectural state; only committed on an execute pass
  mncu_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (req_q.dest_register[REG_IDX_W-1:0]),
    .rd_data_o (rd_data),
    .wr_i      (rf_commit),
    .cc_we_i   (advance),
    .cc_d_i    (cc_d),
    .cc_o      (cc_q)
  );

  mncu_exec u_exec (
    .req_i     (req_q),
    .rd_data_i (rd_data),
    .cc_i      (cc_q),
    .trap_en_i (trap_en_q),
    .res_o     (res_d),
    .rf_wr_o   (rf_wr),
    .cc_d_o    (cc_d)
  );

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.mem_write     = res_q.mem_write;
  assign out_o.write_address = res_q.write_address;
  assign out_o.write_data    = res_q.write_data;
  assign out_o.write_size    = res_q.write_size;
  assign out_o.reg_written   = res_q.reg_written;
  assign out_o.reg_value     = res_q.reg_value;
  assign out_o.flag_n        = res_q.flag_n;
  assign out_o.flag_z        = res_q.flag_z;
  assign out_o.flag_v        = res_q.flag_v;
  assign out_o.flag_c        = res_q.flag_c;
  assign out_o.overflow_trap = res_q.overflow_trap;

`ifndef SYNTHESIS
  a_trap_has_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.overflow_trap |-> out_o.flag_v)
    else $error("overflow trap without V");

  a_one_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.mem_write && out_o.reg_written))
    else $error("result written to both memory and register");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_valid_q)
    else $error("execute pass did not fill result stage");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> req_valid_q)
    else $error("accepted instruction lost from input stage");

  a_cc_only_on_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(cc_q))
    else $error("condition codes changed without execute pass");
`endif
endmodule
